// ----- design/swm_pkg.sv -----
`default_nettype none

package swm_pkg;

    localparam int SAMPLE_W = 32;
    localparam int CFG_W    = 7;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    // One slot of the sorted chain.
    typedef struct packed {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] value;
    } t_entry;

    // Broadcast controls from the top level to every cell.
    typedef struct packed {
        logic accept;   // request taken this cycle
        logic full;     // window complete with this request: drop the oldest
        logic clear;    // size register written: empty the chain
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ----- design/sliding_window_median_top.sv -----
`default_nettype none

// Channel    | Direction | Signals                                  | Payload
// -----------+-----------+------------------------------------------+-----------------
// sample     | in        | i_sample_valid / o_sample_ready          | i_sample [31:0]
// median     | out       | o_median_valid / i_median_ready          | o_median [31:0]
// size reg   | in        | i_cfg_we (no wait, no read-back)         | i_cfg_data [6:0]
//
// One sample request is taken per cycle while o_sample_ready is high; the cell chain sorts each
// one in place (compare, shift-insert and shift-remove are local to each cell and its neighbors).
// A median leaves the output register in the cycle after the request that completes the
// window. A waiting median stalls only requests that would produce another one.
// Reset (synchronous, active low) and a size write empty the window at once; the next
// size-1 requests give no median. No clearing pass: sample slots carry valid bits.

module sliding_window_median_top #(
    parameter int WINDOW_MAX = 64
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_sample_valid,
    output logic                               o_sample_ready,
    input  wire signed [swm_pkg::SAMPLE_W-1:0] i_sample,
    output logic                               o_median_valid,
    input  wire                                i_median_ready,
    output logic signed [swm_pkg::SAMPLE_W-1:0] o_median,
    input  wire                                i_cfg_we,
    input  wire [swm_pkg::CFG_W-1:0]           i_cfg_data
);

    localparam int SW = $clog2(WINDOW_MAX + 1);
    localparam int CW = (SW > swm_pkg::CFG_W) ? SW : swm_pkg::CFG_W;
    localparam logic [SW-1:0] RST_WIN = (WINDOW_MAX < 3) ? SW'(WINDOW_MAX) : SW'(3);
    localparam logic [CW-1:0] MAX_CW  = CW'(WINDOW_MAX);

    logic [SW-1:0]     r_win;
    logic [SW-1:0]     n_win;
    logic [SW-1:0]     r_fill;
    logic              r_out_valid;
    swm_pkg::t_sample  r_median;

    logic [CW-1:0]     cfg_ext;
    logic [CW-1:0]     win_clip;
    logic              accept;
    logic              full;
    swm_pkg::t_sample  oldest;
    swm_pkg::t_sample  median_pick;
    swm_pkg::t_cell_ctrl ctrl;
    logic [WINDOW_MAX-1:0] slot_valid;

    // Neighbor nets: cell g drives cell_entry[g+1], cell_gt[g+1], cell_ins[g], cell_dly[g].
    swm_pkg::t_entry   cell_entry [WINDOW_MAX+1];
    logic              cell_gt    [WINDOW_MAX+1];
    swm_pkg::t_entry   cell_ins   [WINDOW_MAX+1];
    swm_pkg::t_sample  cell_dly   [WINDOW_MAX+1];
    swm_pkg::t_sample  cell_pick  [WINDOW_MAX];

    // Clip the written size: zero acts as one, anything above the chain length as the length.
    assign cfg_ext = CW'(i_cfg_data);
    always_comb begin
        if (cfg_ext == '0) begin
            win_clip = CW'(1);
        end else if (cfg_ext > MAX_CW) begin
            win_clip = MAX_CW;
        end else begin
            win_clip = cfg_ext;
        end
    end
    assign n_win = win_clip[SW-1:0];

    // The window is complete once the held samples plus this request reach the size.
    assign full   = (r_fill == r_win - SW'(1));
    assign accept = i_sample_valid && o_sample_ready;

    // Hold off only a request that would produce a median behind one still waiting.
    assign o_sample_ready = !full || !r_out_valid || i_median_ready;

    // For a size of one the sample leaves right after it enters.
    assign oldest = (r_win == SW'(1)) ? i_sample : cell_dly[0];

    assign ctrl = '{accept: accept, full: full, clear: i_cfg_we};

    // Chain ends: nothing below the first cell, empty slots above the last.
    assign cell_entry[0]        = '0;
    assign cell_gt[0]           = 1'b0;
    assign cell_ins[WINDOW_MAX] = '0;
    assign cell_dly[WINDOW_MAX] = '0;

    for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
        swm_cell #(
            .SW  (SW),
            .IDX (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (ctrl),
            .i_sample    (i_sample),
            .i_oldest    (oldest),
            .i_win       (r_win),
            .i_left      (cell_entry[g]),
            .i_left_gt   (cell_gt[g]),
            .i_right_ins (cell_ins[g+1]),
            .i_right_dly (cell_dly[g+1]),
            .o_entry     (cell_entry[g+1]),
            .o_gt        (cell_gt[g+1]),
            .o_ins       (cell_ins[g]),
            .o_dly       (cell_dly[g]),
            .o_pick      (cell_pick[g])
        );
        assign slot_valid[g] = cell_entry[g+1].valid;
    end

    // Exactly one cell drives its value for the middle rank; the rest drive zero.
    always_comb begin
        median_pick = '0;
        for (int k = 0; k < WINDOW_MAX; k++) begin
            median_pick = median_pick | cell_pick[k];
        end
    end

    // Size register and fill count; a size write empties the window.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win  <= RST_WIN;
            r_fill <= '0;
        end else if (i_cfg_we) begin
            r_win  <= n_win;
            r_fill <= '0;
        end else if (accept && !full) begin
            r_fill <= r_fill + SW'(1);
        end
    end

    // Output register: load on a completing request, drop once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && full) begin
            r_out_valid <= 1'b1;
        end else if (i_median_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && full) begin
            r_median <= median_pick;
        end
    end

    assign o_median_valid = r_out_valid;
    assign o_median       = r_median;

    // The chain never holds a whole window between requests.
    a_fill_below_win: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < r_win)
        else $error("fill count reached window size");

    // Occupied slots match the fill count.
    a_slots_match_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(slot_valid) == int'(r_fill))
        else $error("occupied slots differ from fill count");

    // Occupied slots form one run from the bottom of the chain.
    a_slots_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (slot_valid & (slot_valid + WINDOW_MAX'(1))) == '0)
        else $error("gap in sorted chain");

    // A median appears only after a request that completed the window.
    a_median_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_median_valid) |-> $past(accept && full))
        else $error("median without a completing request");

endmodule

`default_nettype wire

// ----- design/swm_cell.sv -----
`default_nettype none

module swm_cell #(
    parameter int SW  = 7,
    parameter int IDX = 0
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  swm_pkg::t_cell_ctrl   i_ctrl,
    input  swm_pkg::t_sample      i_sample,
    input  swm_pkg::t_sample      i_oldest,
    input  wire [SW-1:0]          i_win,
    input  swm_pkg::t_entry       i_left,
    input  wire                   i_left_gt,
    input  swm_pkg::t_entry       i_right_ins,
    input  swm_pkg::t_sample      i_right_dly,
    output swm_pkg::t_entry       o_entry,
    output logic                  o_gt,
    output swm_pkg::t_entry       o_ins,
    output swm_pkg::t_sample      o_dly,
    output swm_pkg::t_sample      o_pick
);

    localparam logic [SW:0] LOAD_WIN = (SW+1)'(IDX + 2);
    localparam logic [SW:0] PICK_LO  = (SW+1)'(2 * IDX + 1);
    localparam logic [SW:0] PICK_HI  = (SW+1)'(2 * IDX + 2);

    logic             r_valid;
    swm_pkg::t_sample r_value;
    swm_pkg::t_sample r_dly;

    swm_pkg::t_entry  ins;
    swm_pkg::t_entry  n_entry;
    logic [SW:0]      win_ext;
    logic             load_here;
    logic             pick_here;
    logic             ge_old;

    assign win_ext   = {1'b0, i_win};
    assign load_here = (win_ext == LOAD_WIN);
    assign pick_here = (win_ext == PICK_LO) || (win_ext == PICK_HI);

    // Empty slots sort above every sample.
    assign o_gt = !r_valid || (r_value > i_sample);

    // Insert: take the left neighbor if it moves up, else the new sample at the boundary, else keep this slot.
    always_comb begin
        if (i_left_gt) begin
            ins = i_left;
        end else if (o_gt) begin
            ins = '{valid: 1'b1, value: i_sample};
        end else begin
            ins = '{valid: r_valid, value: r_value};
        end
    end

    // Remove: when the window is full, every occupied slot at or above the oldest value pulls from the right.
    assign ge_old  = ins.valid && (ins.value >= i_oldest);
    assign n_entry = (i_ctrl.full && ge_old) ? i_right_ins : ins;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.accept) begin
            r_valid <= n_entry.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_value <= n_entry.value;
            r_dly   <= load_here ? i_sample : i_right_dly;
        end
    end

    assign o_entry = '{valid: r_valid, value: r_value};
    assign o_ins   = ins;
    assign o_dly   = r_dly;
    assign o_pick  = pick_here ? ins.value : '0;

endmodule

`default_nettype wire
